// File: hw/rtl/sha256_stream_hasher_unit_defines.svh
// assertion macros shared by the hasher
`ifndef SHA256_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_STREAM_HASHER_UNIT_DEFINES_SVH

// same-cycle implication
`define SHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sha256 hasher: same-cycle check failed");

// next-cycle implication
`define SHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sha256 hasher: next-cycle check failed");

`endif

// File: hw/rtl/sha_pkg.sv
`default_nettype none

package sha_pkg;

	localparam int unsigned COUNT_W = 61;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] BLOCK_LAST = 6'd63;
	localparam logic [5:0] RND_LAST = 6'd63;

	typedef logic [0:7][31:0] word8_t;
	typedef logic [0:15][31:0] word16_t;

	typedef struct packed {
		logic shift_byte;
		logic shift_word;
	} sched_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
	} round_ctl_t;

	localparam word8_t SHA_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sha_msg_if.sv
`default_nettype none

interface sha_msg_if;
	logic       valid;
	logic       ready;
	logic       has_byte;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output has_byte, output data_byte, output last,
		input ready);
	modport sink (input valid, input has_byte, input data_byte, input last,
		output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sha_dig_if.sv
`default_nettype none

interface sha_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        word_last;

	modport source (output valid, output digest_word, output word_last, input ready);
	modport sink (input valid, input digest_word, input word_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sha_sched.sv
`default_nettype none

module sha_sched (
	input  wire logic              clk,
	input  wire sha_pkg::sched_ctl_t ctl,
	input  wire logic [7:0]        byte_in,
	output logic [31:0]            wt
);
	import sha_pkg::*;

	word16_t      w_q;
	logic [511:0] blk;
	logic [31:0]  w_new;

	assign blk = w_q;
	assign wt = w_q[0];
	assign w_new = small_sig1(w_q[14]) + w_q[9] + small_sig0(w_q[1]) + w_q[0];

	// bytes and schedule words share one shift line, oldest word first
	always_ff @(posedge clk) begin
		if (ctl.shift_byte) begin
			w_q <= {blk[503:0], byte_in};
		end else if (ctl.shift_word) begin
			w_q <= {blk[479:0], w_new};
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sha_round.sv
`default_nettype none

module sha_round (
	input  wire logic              clk,
	input  wire sha_pkg::round_ctl_t ctl,
	input  wire sha_pkg::word8_t   chain,
	input  wire logic [31:0]       k,
	input  wire logic [31:0]       wt,
	output sha_pkg::word8_t        work
);
	import sha_pkg::*;

	word8_t      work_q;
	logic [31:0] ch;
	logic [31:0] mj;
	logic [31:0] t1;
	logic [31:0] t2;

	assign work = work_q;

	always_comb begin
		ch = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
		mj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
		t1 = work_q[7] + big_sig1(work_q[4]) + ch + k + wt;
		t2 = big_sig0(work_q[0]) + mj;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			work_q <= chain;
		end else if (ctl.step) begin
			work_q <= {t1 + t2, work_q[0], work_q[1], work_q[2],
				work_q[3] + t1, work_q[4], work_q[5], work_q[6]};
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sha256_stream_hasher_unit.sv
// channel | dir | handshake   | payload
// msg     | in  | valid/ready | has_byte, data_byte[7:0], last
// dig     | out | valid/ready | digest_word[31:0], word_last
//
// message bytes are taken one per cycle while msg.ready is high; each full 64-byte block then
// adds a compression (64 rounds in one shared round unit, then the chaining add)
// an item marked last adds the padding bytes up to the block end,
// one or two compressions and eight digest words
// arst_n clears the sequencer and counters and loads the chaining words with the initial hash; no clearing pass
// msg.ready is low while compressing, padding or sending the digest
`default_nettype none
`include "sha256_stream_hasher_unit_defines.svh"

module sha256_stream_hasher_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sha_msg_if.sink    msg,
	sha_dig_if.source  dig
);
	import sha_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_FINAL = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [1:0] RET_IDLE = 2'd0;
	localparam logic [1:0] RET_PAD  = 2'd1;
	localparam logic [1:0] RET_OUT  = 2'd2;

	localparam logic [2:0] LAST_WORD = 3'd7;

	logic [2:0]         state_q;
	logic [1:0]         ret_q;
	logic [5:0]         pos_q;
	logic [COUNT_W-1:0] count_q;
	logic [5:0]         rnd_q;
	logic               first_q;
	logic               len_ok_q;
	logic [2:0]         out_idx_q;
	word8_t             chain_q;

	word8_t      work;
	logic [31:0] wt;
	logic        accept;
	logic        out_accept;
	logic        full;
	logic [5:0]  pos_next;
	logic [63:0] bit_len;
	logic [7:0]  len_byte;
	logic [7:0]  pad_byte;
	logic [7:0]  feed_byte;
	sched_ctl_t  sched_ctl;
	round_ctl_t  round_ctl;

	assign msg.ready = (state_q == ST_IDLE);
	assign accept = msg.valid && msg.ready;
	assign out_accept = dig.valid && dig.ready;

	assign dig.valid = (state_q == ST_OUT);
	assign dig.digest_word = chain_q[out_idx_q];
	assign dig.word_last = (out_idx_q == LAST_WORD);

	always_comb begin
		bit_len = {count_q, 3'b000};
		len_byte = 8'(bit_len >> {~pos_q[2:0], 3'b000});
		if (first_q) begin
			pad_byte = PAD_BYTE;
		end else if (len_ok_q && pos_q[5:3] == 3'b111) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
		feed_byte = (state_q == ST_PAD) ? pad_byte : msg.data_byte;
		sched_ctl.shift_byte = (accept && msg.has_byte) || (state_q == ST_PAD);
		sched_ctl.shift_word = (state_q == ST_ROUND);
		full = sched_ctl.shift_byte && (pos_q == BLOCK_LAST);
		pos_next = pos_q + 6'(msg.has_byte);
		round_ctl.load = full;
		round_ctl.step = (state_q == ST_ROUND);
	end

	sha_sched u_sched (
		.clk     (clk),
		.ctl     (sched_ctl),
		.byte_in (feed_byte),
		.wt      (wt)
	);

	sha_round u_round (
		.clk   (clk),
		.ctl   (round_ctl),
		.chain (chain_q),
		.k     (SHA_K[rnd_q]),
		.wt    (wt),
		.work  (work)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ret_q     <= RET_IDLE;
			pos_q     <= '0;
			count_q   <= '0;
			rnd_q     <= '0;
			first_q   <= 1'b0;
			len_ok_q  <= 1'b0;
			out_idx_q <= '0;
			chain_q   <= SHA_IV;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (msg.has_byte) begin
							pos_q   <= pos_next;
							count_q <= count_q + 1'b1;
						end
						if (msg.last) begin
							first_q  <= 1'b1;
							len_ok_q <= (pos_next[5:3] != 3'b111);
						end
						if (full) begin
							state_q <= ST_ROUND;
							rnd_q   <= '0;
							ret_q   <= msg.last ? RET_PAD : RET_IDLE;
						end else if (msg.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pos_q   <= pos_q + 1'b1;
					first_q <= 1'b0;
					if (full) begin
						state_q  <= ST_ROUND;
						rnd_q    <= '0;
						ret_q    <= len_ok_q ? RET_OUT : RET_PAD;
						len_ok_q <= 1'b1;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RND_LAST) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					for (int j = 0; j < 8; j++) begin
						chain_q[j] <= chain_q[j] + work[j];
					end
					out_idx_q <= '0;
					case (ret_q)
						RET_PAD: state_q <= ST_PAD;
						RET_OUT: state_q <= ST_OUT;
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_OUT: begin
					if (out_accept) begin
						out_idx_q <= out_idx_q + 1'b1;
						if (out_idx_q == LAST_WORD) begin
							state_q <= ST_IDLE;
							chain_q <= SHA_IV;
							count_q <= '0;
							pos_q   <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SHA_ASSERT_IMP(a_no_overlap, clk, arst_n, dig.valid, !msg.ready)
	`SHA_ASSERT_NXT(a_round_end, clk, arst_n, state_q == ST_ROUND && rnd_q == RND_LAST, state_q == ST_FINAL)
	`SHA_ASSERT_NXT(a_back_idle, clk, arst_n, out_accept && dig.word_last, msg.ready && pos_q == '0 && count_q == '0)

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned RAND_ITEMS = 320;
	localparam int unsigned LONG_HOLD = 400;

	localparam logic [255:0] DG_EMPTY =
		256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
	localparam logic [255:0] DG_ABC =
		256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

	localparam logic [31:0] HASH_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic         hb;
		logic [7:0]   db;
		logic         lst;
		logic         fixed;
		logic [255:0] dg;
	} stim_row_t;

	localparam int unsigned N_DIR = 16;
	localparam stim_row_t DIR_ROWS [N_DIR] = '{
		'{1'b0, 8'h5a, 1'b0, 1'b0, 256'h0},
		'{1'b0, 8'h00, 1'b1, 1'b1, DG_EMPTY},
		'{1'b1, 8'h61, 1'b0, 1'b0, 256'h0},
		'{1'b1, 8'h62, 1'b0, 1'b0, 256'h0},
		'{1'b0, 8'hff, 1'b0, 1'b0, 256'h0},
		'{1'b1, 8'h63, 1'b1, 1'b1, DG_ABC},
		'{1'b0, 8'hff, 1'b1, 1'b1, DG_EMPTY},
		'{1'b1, 8'h00, 1'b0, 1'b0, 256'h0},
		'{1'b1, 8'hff, 1'b0, 1'b0, 256'h0},
		'{1'b0, 8'hff, 1'b0, 1'b0, 256'h0},
		'{1'b1, 8'h80, 1'b0, 1'b0, 256'h0},
		'{1'b1, 8'hff, 1'b1, 1'b0, 256'h0},
		'{1'b1, 8'h00, 1'b1, 1'b0, 256'h0},
		'{1'b1, 8'h7f, 1'b0, 1'b0, 256'h0},
		'{1'b0, 8'h00, 1'b1, 1'b0, 256'h0},
		'{1'b0, 8'h3c, 1'b1, 1'b1, DG_EMPTY}
	};

	typedef struct packed {
		logic [31:0] word;
		logic        fin;
	} dig_word_t;

	logic clk;
	logic arst_n;

	sha_msg_if msg_ch ();
	sha_dig_if dig_ch ();

	sha256_stream_hasher_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.dig    (dig_ch)
	);

	// running hash of the message so far
	logic [31:0] hash_words [8];
	logic [7:0]  blk_buf [64];
	logic [60:0] byte_cnt;

	dig_word_t   digest_q [$];
	int unsigned err_cnt = 0;
	int unsigned msg_items;
	int unsigned cycle_cnt = 0;
	bit          tx_burst;
	bit          hold_req;

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (err_cnt < 100)
			$display("t=%0t %s: got %h want %h", $realtime, what, got, want);
		err_cnt++;
	endtask

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void clear_hash();
		for (int j = 0; j < 8; j++)
			hash_words[j] = HASH_INIT[j];
		for (int j = 0; j < 64; j++)
			blk_buf[j] = 8'h00;
		byte_cnt = '0;
	endfunction

	function automatic void compress_buf();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wt, x2, x15, s0, s1, ch, mj, t1, t2;
		for (int j = 0; j < 16; j++)
			w[j] = {blk_buf[4*j], blk_buf[4*j+1], blk_buf[4*j+2], blk_buf[4*j+3]};
		for (int j = 0; j < 8; j++)
			v[j] = hash_words[j];
		for (int t = 0; t < 64; t++) begin
			if (t < 16) begin
				wt = w[t];
			end else begin
				x2 = w[(t - 2) & 15];
				x15 = w[(t - 15) & 15];
				wt = (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10)) + w[(t - 7) & 15]
					+ (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + w[t & 15];
				w[t & 15] = wt;
			end
			s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			t1 = v[7] + s1 + ch + ROUND_K[t] + wt;
			s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
			mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t2 = s0 + mj;
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++)
			hash_words[j] = hash_words[j] + v[j];
	endfunction

	function automatic void sha_absorb(input logic hb, input logic [7:0] db,
		input logic lst, output logic done, output logic [255:0] dg);
		logic [5:0]  pos;
		logic [63:0] bit_len;
		done = 1'b0;
		dg = '0;
		if (hb) begin
			blk_buf[byte_cnt[5:0]] = db;
			byte_cnt = byte_cnt + 1'b1;
			if (byte_cnt[5:0] == 6'd0)
				compress_buf();
		end
		if (lst) begin
			pos = byte_cnt[5:0];
			blk_buf[pos] = 8'h80;
			for (int j = int'(pos) + 1; j < 64; j++)
				blk_buf[j] = 8'h00;
			if (pos >= 6'd56) begin
				compress_buf();
				for (int j = 0; j < 56; j++)
					blk_buf[j] = 8'h00;
			end
			bit_len = {byte_cnt, 3'b000};
			for (int j = 0; j < 8; j++)
				blk_buf[63 - j] = bit_len[8*j +: 8];
			compress_buf();
			for (int j = 0; j < 8; j++)
				dg[255 - 32*j -: 32] = hash_words[j];
			done = 1'b1;
			clear_hash();
		end
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic put_item(input logic hb, input logic [7:0] db, input logic lst,
		input logic fixed, input logic [255:0] fixed_dg);
		int           gap;
		logic         done;
		logic [255:0] dg;
		logic [255:0] sel;
		dig_word_t    dw;
		gap = tx_burst ? 0 : idle_len();
		if (gap > 0) begin
			msg_ch.valid <= 1'b0;
			msg_ch.data_byte <= 8'($urandom_range(0, 255));
			repeat (gap) @(posedge clk);
		end
		msg_ch.valid <= 1'b1;
		msg_ch.has_byte <= hb;
		msg_ch.data_byte <= db;
		msg_ch.last <= lst;
		do @(posedge clk); while (!msg_ch.ready);
		sha_absorb(hb, db, lst, done, dg);
		if (hb || lst)
			msg_items++;
		if (done) begin
			sel = fixed ? fixed_dg : dg;
			for (int k = 0; k < 8; k++) begin
				dw.word = sel[255 - 32*k -: 32];
				dw.fin = (k == 7);
				digest_q.push_back(dw);
			end
		end
	endtask

	task automatic put_message(input int len);
		logic inline_end;
		inline_end = 1'b0;
		tx_burst = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < len; i++) begin
			// ignored item between bytes
			if ($urandom_range(0, 9) == 0)
				put_item(1'b0, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
			inline_end = (i == len - 1) && ($urandom_range(0, 1) == 1);
			put_item(1'b1, 8'($urandom_range(0, 255)), inline_end, 1'b0, '0);
		end
		if (!inline_end)
			put_item(1'b0, 8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
	endtask

	// digest side
	initial begin
		int        r;
		int        rx_stall;
		int        rx_free;
		dig_word_t want;
		rx_stall = 0;
		rx_free = 0;
		dig_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (dig_ch.valid && dig_ch.ready) begin
				if (digest_q.size() == 0) begin
					report_mismatch("unexpected digest word", dig_ch.digest_word, '0);
				end else begin
					want = digest_q.pop_front();
					if (dig_ch.digest_word !== want.word)
						report_mismatch("digest_word", dig_ch.digest_word, want.word);
					if (dig_ch.word_last !== want.fin)
						report_mismatch("word_last", 32'(dig_ch.word_last), 32'(want.fin));
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				rx_stall = LONG_HOLD;
			end
			if (rx_stall > 0) begin
				rx_stall--;
				dig_ch.ready <= 1'b0;
			end else if (rx_free > 0) begin
				rx_free--;
				dig_ch.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					rx_free = $urandom_range(20, 80);
					dig_ch.ready <= 1'b1;
				end else if (r < 75) begin
					dig_ch.ready <= 1'b1;
				end else if (r < 97) begin
					rx_stall = $urandom_range(0, 3);
					dig_ch.ready <= 1'b0;
				end else begin
					rx_stall = $urandom_range(10, 50);
					dig_ch.ready <= 1'b0;
				end
			end
		end
	end

	initial begin
		int len;
		int msg_no;
		clk = 1'b0;
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.has_byte = 1'b0;
		msg_ch.data_byte = 8'h00;
		msg_ch.last = 1'b0;
		msg_items = 0;
		tx_burst = 1'b0;
		hold_req = 1'b0;
		msg_no = 0;
		clear_hash();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			put_item(DIR_ROWS[i].hb, DIR_ROWS[i].db, DIR_ROWS[i].lst,
				DIR_ROWS[i].fixed, DIR_ROWS[i].dg);

		msg_items = 0;
		while (msg_items < RAND_ITEMS) begin
			case ($urandom_range(0, 19))
				0, 1: len = 0;
				2: len = 55;
				3: len = 56;
				4: len = 57 + $urandom_range(0, 6);
				5: len = 64;
				6: begin
					case ($urandom_range(0, 3))
						0: len = 65;
						1: len = 119;
						2: len = 120;
						default: len = 128;
					endcase
				end
				default: len = $urandom_range(1, 20);
			endcase
			// receiver blocks for a long time while items keep coming
			if (msg_no == 2)
				hold_req = 1'b1;
			put_message(len);
			msg_no++;
		end
		msg_ch.valid <= 1'b0;

		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (err_cnt == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
